FILE: design/hsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_pkg
// shared widths, codes and state type of the hashed sample counter
// ----------------------------------------------------------------------------
package hsc_pkg;

    // table geometry defaults
    localparam int DEF_TABLE_SIZE = 256;
    localparam int DEF_COUNT_BITS = 32;

    // word field widths
    localparam int CMD_W     = 2;
    localparam int KEY_W     = 64;
    localparam int KEY_IDX_W = $clog2(KEY_W);
    localparam int CAT_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int BUCKET_W  = 8;
    localparam int TOTAL_W   = 40;

    localparam logic [CAT_W-1:0]   ALL_CATEGORY = CAT_W'(64);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RECORD = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_ZERO_KEY = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_PROBE,
        S_QUERY,
        S_FINISH
    } t_state;

endpackage

FILE: design/hashed_sample_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_sample_counter
// open-addressed hash table of 64-bit bitmask keys with saturating counts
// ----------------------------------------------------------------------------
//
//  channel | handshake                   | fields
//  --------+-----------------------------+----------------------------------
//  in      | i_valid / o_stall           | i_command, i_key, i_category
//  out     | o_valid / i_stall           | o_status, o_bucket, o_total
//
//  one word in gives one word out; a word is taken only while the engine is idle
//  record: the key modulo takes one 16-bit key digit at a time, msb first (a
//    reciprocal multiply then a correcting subtract), then one slot read per
//    cycle (pipelined) until the key, an empty slot or a full table turns up;
//    the single memory read port sets the pace
//  clear: one slot written per cycle; query: reads every slot, summing matches
//  reset starts a clearing pass over every slot with o_stall held high
//  a finished word waits in the output register while the next word is taken
//
module hashed_sample_counter
    import hsc_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [CMD_W-1:0]    i_command,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [CAT_W-1:0]    i_category,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [BUCKET_W-1:0] o_bucket,
    output logic [TOTAL_W-1:0]  o_total
);

    localparam int AW      = $clog2(TABLE_SIZE);          // slot index width
    localparam int CW      = $clog2(TABLE_SIZE + 1);      // slot counter width
    localparam int ENTRY_W = KEY_W + COUNT_BITS;
    localparam int SUM_W   = ((TOTAL_W > COUNT_BITS) ? TOTAL_W : COUNT_BITS) + 1;

    // key modulo: 16-bit digits, msb first, a multiply and a subtract phase each
    localparam int DIG_W    = 16;
    localparam int N_DIG    = KEY_W / DIG_W;
    localparam int STEP_W   = $clog2(N_DIG) + 1;          // digit index and phase
    localparam int V_W      = AW + DIG_W;
    localparam int RECIP_SH = 32;
    localparam int PROD_W   = V_W + RECIP_SH;

    localparam logic [AW-1:0]       LAST_SLOT = AW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0]       LAST_CNT  = CW'(TABLE_SIZE - 1);
    localparam logic [CW-1:0]       ALL_CNT   = CW'(TABLE_SIZE);
    localparam logic [V_W-1:0]      HASH_MOD  = V_W'(TABLE_SIZE - 1);
    localparam logic [RECIP_SH-1:0] RECIP     =
        RECIP_SH'((64'd1 << RECIP_SH) / 64'(TABLE_SIZE - 1));

    // slot store: key in the upper bits, count in the lower bits
    logic [ENTRY_W-1:0] r_mem [TABLE_SIZE];
    logic [ENTRY_W-1:0] r_rd_data;

    t_state                r_state, n_state;
    logic                  r_init, n_init;       // clearing pass after reset
    logic [KEY_W-1:0]      r_key, n_key;
    logic [CAT_W-1:0]      r_cat, n_cat;
    logic [AW-1:0]         r_addr, n_addr;       // read / clear address
    logic [CW-1:0]         r_issue_cnt, n_issue_cnt;
    logic [CW-1:0]         r_chk_cnt, n_chk_cnt;
    logic [STEP_W-1:0]     r_step, n_step;       // modulo digit index, multiply phase
    logic [V_W-1:0]        r_quot, n_quot;       // quotient estimate of the digit step
    logic [AW-1:0]         r_rem, n_rem;
    logic                  r_rvalid;             // r_rd_data holds a requested slot
    logic [AW-1:0]         r_ridx;               // slot index of r_rd_data
    logic [TOTAL_W-1:0]    r_sum, n_sum;
    logic [STATUS_W-1:0]   r_pend_status, n_pend_status;
    logic [BUCKET_W-1:0]   r_pend_bucket, n_pend_bucket;
    logic [TOTAL_W-1:0]    r_pend_total, n_pend_total;
    logic                  r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]   r_ostatus, n_ostatus;
    logic [BUCKET_W-1:0]   r_obucket, n_obucket;
    logic [TOTAL_W-1:0]    r_ototal, n_ototal;

    logic                  rd_en;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ENTRY_W-1:0]    mem_wdata;

    logic [AW-1:0]         addr_inc;
    logic [STEP_W-2:0]     hash_dig;
    logic [V_W-1:0]        hash_v;
    logic [PROD_W-1:0]     hash_prod;
    logic [V_W-1:0]        hash_qm;
    logic [V_W-1:0]        hash_diff;
    logic [AW-1:0]         hash_rem;
    logic [KEY_W-1:0]      rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  slot_hit;
    logic                  cat_hit;
    logic [SUM_W-1:0]      sum_ext;
    logic [TOTAL_W-1:0]    sum_sat;
    logic [BUCKET_W+AW-1:0] ridx_wide;

    // datapath helpers
    always_comb begin
        addr_inc  = (r_addr == LAST_SLOT) ? '0 : r_addr + AW'(1);

        // one digit step of key modulo (TABLE_SIZE-1): the reciprocal estimate
        // of the quotient is low by at most one, so one subtract corrects it
        hash_dig  = r_step[STEP_W-1:1];
        hash_v    = {r_rem, r_key[hash_dig*DIG_W +: DIG_W]};
        hash_prod = PROD_W'(hash_v) * PROD_W'(RECIP);
        hash_qm   = r_quot * HASH_MOD;
        hash_diff = hash_v - hash_qm;
        hash_rem  = (hash_diff >= HASH_MOD) ? AW'(hash_diff - HASH_MOD) : AW'(hash_diff);

        rd_key    = r_rd_data[ENTRY_W-1 -: KEY_W];
        rd_cnt    = r_rd_data[COUNT_BITS-1:0];
        cnt_inc   = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
        slot_hit  = (rd_key == r_key) || (rd_key == '0);

        // category match for a query; out-of-range categories match nothing
        if (r_cat == ALL_CATEGORY) begin
            cat_hit = 1'b1;
        end else if (!r_cat[CAT_W-1]) begin
            cat_hit = rd_key[r_cat[KEY_IDX_W-1:0]];
        end else begin
            cat_hit = 1'b0;
        end

        sum_ext = SUM_W'(r_sum) + SUM_W'(cat_hit ? rd_cnt : '0);
        sum_sat = (sum_ext > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];

        ridx_wide = {BUCKET_W'(0), r_ridx};
    end

    // next state and control
    always_comb begin
        n_state       = r_state;
        n_init        = r_init;
        n_key         = r_key;
        n_cat         = r_cat;
        n_addr        = r_addr;
        n_issue_cnt   = r_issue_cnt;
        n_chk_cnt     = r_chk_cnt;
        n_step        = r_step;
        n_quot        = r_quot;
        n_rem         = r_rem;
        n_sum         = r_sum;
        n_pend_status = r_pend_status;
        n_pend_bucket = r_pend_bucket;
        n_pend_total  = r_pend_total;
        n_ovalid      = r_ovalid;
        n_ostatus     = r_ostatus;
        n_obucket     = r_obucket;
        n_ototal      = r_ototal;
        rd_en         = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_addr;
        mem_wdata     = '0;

        // output word taken downstream
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key         = i_key;
                    n_cat         = i_category;
                    n_pend_status = ST_DONE;
                    n_pend_bucket = '0;
                    n_pend_total  = '0;
                    n_addr        = '0;
                    n_issue_cnt   = '0;
                    n_chk_cnt     = '0;
                    n_sum         = '0;
                    case (t_cmd'(i_command))
                        CMD_RECORD: begin
                            if (i_key == '0) begin
                                n_pend_status = ST_ZERO_KEY;
                                n_state       = S_FINISH;
                            end else begin
                                n_rem   = '0;
                                n_step  = '1;
                                n_state = S_HASH;
                            end
                        end
                        CMD_CLEAR: n_state = S_CLEAR;
                        CMD_QUERY: n_state = S_QUERY;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                mem_wdata = '0;
                n_addr    = addr_inc;
                if (r_addr == LAST_SLOT) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_FINISH;
                end
            end
            S_HASH: begin
                n_step = r_step - STEP_W'(1);
                if (r_step[0]) begin
                    n_quot = hash_prod[RECIP_SH +: V_W];
                end else begin
                    n_rem = hash_rem;
                    if (r_step == '0) begin
                        n_addr  = hash_rem;
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_issue_cnt != ALL_CNT) begin
                    rd_en       = 1'b1;
                    n_addr      = addr_inc;
                    n_issue_cnt = r_issue_cnt + CW'(1);
                end
                if (r_rvalid) begin
                    if (slot_hit) begin
                        mem_we        = 1'b1;
                        mem_waddr     = r_ridx;
                        mem_wdata     = {r_key, cnt_inc};
                        n_pend_bucket = ridx_wide[BUCKET_W-1:0];
                        n_state       = S_FINISH;
                    end else if (r_chk_cnt == LAST_CNT) begin
                        n_pend_status = ST_FULL;
                        n_state       = S_FINISH;
                    end else begin
                        n_chk_cnt = r_chk_cnt + CW'(1);
                    end
                end
            end
            S_QUERY: begin
                if (r_issue_cnt != ALL_CNT) begin
                    rd_en       = 1'b1;
                    n_addr      = addr_inc;
                    n_issue_cnt = r_issue_cnt + CW'(1);
                end
                if (r_rvalid) begin
                    n_sum = sum_sat;
                    if (r_chk_cnt == LAST_CNT) begin
                        n_pend_total = sum_sat;
                        n_state      = S_FINISH;
                    end else begin
                        n_chk_cnt = r_chk_cnt + CW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_pend_status;
                    n_obucket = r_pend_bucket;
                    n_ototal  = r_pend_total;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_addr      <= '0;
            r_issue_cnt <= '0;
            r_chk_cnt   <= '0;
            r_step      <= '0;
            r_rvalid    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_init      <= n_init;
            r_addr      <= n_addr;
            r_issue_cnt <= n_issue_cnt;
            r_chk_cnt   <= n_chk_cnt;
            r_step      <= n_step;
            r_rvalid    <= rd_en;
            r_ovalid    <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_cat         <= n_cat;
        r_quot        <= n_quot;
        r_rem         <= n_rem;
        r_sum         <= n_sum;
        r_ridx        <= r_addr;
        r_pend_status <= n_pend_status;
        r_pend_bucket <= n_pend_bucket;
        r_pend_total  <= n_pend_total;
        r_ostatus     <= n_ostatus;
        r_obucket     <= n_obucket;
        r_ototal      <= n_ototal;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_status = r_ostatus;
    assign o_bucket = r_obucket;
    assign o_total  = r_ototal;

endmodule

FILE: design/hsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsc_checker
// port-level checks on the hashed sample counter
// ----------------------------------------------------------------------------
module hsc_checker
    import hsc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic [CMD_W-1:0]    i_command,
    input logic [KEY_W-1:0]    i_key,
    input logic [CAT_W-1:0]    i_category,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [BUCKET_W-1:0] o_bucket,
    input logic [TOTAL_W-1:0]  o_total
);

    // clearing pass follows reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input not stalled after reset");

    // every accepted word makes the input stall in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input taken again right after an accept");

    // non-done replies (zero key ignored, table full dropped) carry no bucket or total
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_DONE)) |-> (o_bucket == '0 && o_total == '0))
        else $error("non-done status with bucket or total");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_bucket)
                                  && $stable(o_total)))
        else $error("stalled output word changed");

endmodule

bind hashed_sample_counter hsc_checker u_hsc_checker (.*);

FILE: tb/sv/tb_hashed_sample_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_sample_counter
// self-checking bench for the hashed sample counter: a short table of opening
// words, then random traffic built around key pools, colliding keys and a
// table fill, each reply checked against a typed reply or a model of the hash table
// ----------------------------------------------------------------------------
module tb_hashed_sample_counter;
    import hsc_pkg::*;

    localparam int TBL_SIZE       = DEF_TABLE_SIZE;
    localparam int CNT_BITS       = DEF_COUNT_BITS;
    localparam int WORD_TARGET    = 650;
    localparam int IDLE_PCT       = 35;
    localparam int POOL_DEPTH     = 24;
    // long receiver hold-off, well past one full probe so the engine backs up
    localparam int HOLD_CYCLES    = 800;
    // worst gap: hold-off plus a record that probes every slot, several times over
    localparam int WATCHDOG_LIMIT = 6000;
    // after the last reply: room for one more clear or query to show up
    localparam int DRAIN_CYCLES   = 2 * TBL_SIZE + 80;

    // command code the block does not use; must come back as a plain done
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [CAT_W-1:0] CAT_TOP    = '1;
    localparam logic             TYPED      = 1'b1;
    localparam logic             PREDICTED  = 1'b0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BUCKET_W-1:0] bucket;
        logic [TOTAL_W-1:0]  total;
    } t_reply;

    // one opening word; want is used only where typed is set
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [CAT_W-1:0] cat;
        logic             typed;
        t_reply           want;
    } t_plan_row;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_stall;
    logic [CMD_W-1:0]    i_command  = '0;
    logic [KEY_W-1:0]    i_key      = '0;
    logic [CAT_W-1:0]    i_category = '0;
    logic                o_valid;
    logic                i_stall    = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [BUCKET_W-1:0] o_bucket;
    logic [TOTAL_W-1:0]  o_total;

    hashed_sample_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_key      (i_key),
        .i_category (i_category),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_bucket   (o_bucket),
        .o_total    (o_total)
    );

    // model copy of the hash table
    logic [KEY_W-1:0]    slot_key [TBL_SIZE];
    logic [CNT_BITS-1:0] slot_cnt [TBL_SIZE];

    // replies owed by the block, oldest first
    t_reply           reply_fifo [$];
    // recently recorded keys, drawn again to build up counts
    logic [KEY_W-1:0] key_pool [$];

    int n_sent          = 0;
    int n_checked       = 0;
    int n_mismatch      = 0;
    int n_dropped       = 0;
    int n_queries       = 0;
    int n_offer_stalled = 0;

    // both sides stop idling while quiet is set; hold_req asks for the long hold-off
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < TBL_SIZE; i++) begin
            slot_key[i] = '0;
            slot_cnt[i] = '0;
        end
    endfunction

    // applies one word to the model table and returns the reply it earns
    function automatic t_reply table_step(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] key,
                                          input logic [CAT_W-1:0] cat);
        t_reply           r;
        int               idx;
        int               found;
        logic             hit;
        logic [TOTAL_W:0] sum;
        r     = '0;
        found = -1;
        sum   = '0;
        case (cmd)
            CMD_RECORD: begin
                if (key == '0) begin
                    r.status = ST_ZERO_KEY;
                end else begin
                    // home slot is key mod (size - 1), then linear probe with wrap
                    idx = int'(key % 64'(TBL_SIZE - 1));
                    for (int n = 0; n < TBL_SIZE && found < 0; n++) begin
                        if (slot_key[idx] == key || slot_key[idx] == '0) begin
                            found = idx;
                        end else begin
                            idx = (idx + 1) % TBL_SIZE;
                        end
                    end
                    if (found >= 0) begin
                        slot_key[found] = key;
                        if (slot_cnt[found] != '1) begin
                            slot_cnt[found] = slot_cnt[found] + 1'b1;
                        end
                        r.bucket = BUCKET_W'(found);
                    end else begin
                        r.status = ST_FULL;
                        n_dropped++;
                    end
                end
            end
            CMD_CLEAR: begin
                wipe_table();
            end
            CMD_QUERY: begin
                n_queries++;
                for (int i = 0; i < TBL_SIZE; i++) begin
                    hit = (cat == ALL_CATEGORY) ||
                          (cat < ALL_CATEGORY && slot_key[i][cat[KEY_IDX_W-1:0]]);
                    if (hit) begin
                        sum = sum + slot_cnt[i];
                        if (sum > TOTAL_MAX) begin
                            sum = TOTAL_MAX;
                        end
                    end
                end
                r.total = sum[TOTAL_W-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_plan_row make_row(input logic [CMD_W-1:0]    cmd,
                                           input logic [KEY_W-1:0]    key,
                                           input logic [CAT_W-1:0]    cat,
                                           input logic                typed,
                                           input logic [STATUS_W-1:0] status,
                                           input logic [BUCKET_W-1:0] bucket,
                                           input logic [TOTAL_W-1:0]  total);
        t_plan_row row;
        row.cmd         = cmd;
        row.key         = key;
        row.cat         = cat;
        row.typed       = typed;
        row.want.status = status;
        row.want.bucket = bucket;
        row.want.total  = total;
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CAT_W-1:0] pick_category();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3) begin
            return ALL_CATEGORY;
        end else if (pick < 4) begin
            // above the all-samples index: never matches
            return CAT_W'($urandom_range(127, 65));
        end
        return CAT_W'($urandom_range(63));
    endfunction

    // record keys: repeats, shared home slots near the wrap, sparse masks, zero
    function automatic logic [KEY_W-1:0] pick_key();
        int               pick;
        int unsigned      home;
        logic [KEY_W-1:0] k;
        pick = $urandom_range(99);
        if (pick < 8) begin
            k = '0;
        end else if (pick < 45 && key_pool.size() > 0) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (pick < 65) begin
            // same home slot as other keys; mostly the last few slots so probes wrap
            home = ($urandom_range(3) == 0) ? $urandom_range(254) : 251 + $urandom_range(3);
            k    = rand_word();
            k    = k - (k % 64'(TBL_SIZE - 1)) + 64'(home);
        end else if (pick < 80) begin
            k = (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63));
        end else begin
            k = rand_word();
        end
        if (k != '0) begin
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH) begin
                void'(key_pool.pop_front());
            end
        end
        return k;
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        n_mismatch++;
    endtask

    // offers one word, holds it until taken, then books the reply it owes
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [KEY_W-1:0] key,
                             input logic [CAT_W-1:0] cat,
                             input logic             typed,
                             input t_reply           typed_reply);
        t_reply r;
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_key      <= key;
        i_category <= cat;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = table_step(cmd, key, cat);
        reply_fifo.push_back(typed ? typed_reply : r);
        n_sent++;
    endtask

    task automatic mixed_burst(input int count);
        int               pick;
        logic [CMD_W-1:0] cmd;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                cmd = CMD_RECORD;
            end else if (pick < 86) begin
                cmd = CMD_QUERY;
            end else if (pick < 94) begin
                cmd = CMD_UNUSED;
            end else begin
                cmd = CMD_CLEAR;
            end
            send_word(cmd, (cmd == CMD_RECORD) ? pick_key() : rand_word(),
                      pick_category(), PREDICTED, '0);
        end
    endtask

    // clear, fill every slot with fresh keys (querying now and then), push a few more so
    // they drop, revisit old keys on the full table, record a zero key, query all, then clear again
    task automatic fill_table();
        logic [KEY_W-1:0] held [$];
        logic [KEY_W-1:0] k;
        send_word(CMD_CLEAR, rand_word(), pick_category(), PREDICTED, '0);
        for (int i = 0; i < TBL_SIZE + 4; i++) begin
            do begin
                k = rand_word();
            end while (k == '0);
            held.push_back(k);
            send_word(CMD_RECORD, k, pick_category(), PREDICTED, '0);
            if (i % 64 == 63) begin
                send_word(CMD_QUERY, rand_word(), pick_category(), PREDICTED, '0);
            end
        end
        repeat (8) begin
            send_word(CMD_RECORD, held[$urandom_range(TBL_SIZE - 1)], pick_category(),
                      PREDICTED, '0);
        end
        send_word(CMD_RECORD, '0, pick_category(), PREDICTED, '0);
        send_word(CMD_QUERY, rand_word(), ALL_CATEGORY, PREDICTED, '0);
        send_word(CMD_CLEAR, rand_word(), pick_category(), PREDICTED, '0);
    endtask

    // receiving side: checks each reply word, then picks the next stall
    initial begin : reply_side
        t_reply want;
        int     hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_valid && o_stall) begin
                n_offer_stalled++;
            end
            if (o_valid && !i_stall) begin
                if (reply_fifo.size() == 0) begin
                    report_mismatch($sformatf("reply word with nothing owed: %0d %0d %0d",
                                              o_status, o_bucket, o_total));
                end else begin
                    want = reply_fifo.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("reply %0d status got %0d want %0d",
                                                  n_checked, o_status, want.status));
                    end
                    if (o_bucket !== want.bucket) begin
                        report_mismatch($sformatf("reply %0d bucket got %0d want %0d",
                                                  n_checked, o_bucket, want.bucket));
                    end
                    if (o_total !== want.total) begin
                        report_mismatch($sformatf("reply %0d total got %0d want %0d",
                                                  n_checked, o_total, want.total));
                    end
                    n_checked++;
                end
            end
            // the long hold-off is counted here, independent of the sender
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ends the run if no word moves on either side for too long
    initial begin : watchdog
        int still;
        still = 0;
        while (still < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                still = 0;
            end else begin
                still++;
            end
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_plan_row rows [$];
        int        episode;
        wipe_table();

        // empty table after reset
        rows.push_back(make_row(CMD_QUERY, '0, ALL_CATEGORY, TYPED, ST_DONE, '0, '0));
        // zero key is ignored
        rows.push_back(make_row(CMD_RECORD, '0, '0, TYPED, ST_ZERO_KEY, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'd1, '0, TYPED, ST_DONE, 8'd1, '0));
        rows.push_back(make_row(CMD_RECORD, 64'd1, CAT_TOP, TYPED, ST_DONE, 8'd1, '0));
        // same home slot as key 1, probes one up
        rows.push_back(make_row(CMD_RECORD, 64'd256, '0, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'd254, '0, TYPED, ST_DONE, 8'd254, '0));
        // home 254 again: lands on the last slot, then wraps to slot 0
        rows.push_back(make_row(CMD_RECORD, 64'd509, '0, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'd764, '0, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, '1, '0, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'h8000_0000_0000_0000, '0, PREDICTED,
                                ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '1, '0, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '0, 7'd63, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '0, ALL_CATEGORY, PREDICTED, ST_DONE, '0, '0));
        // categories above the all-samples index match nothing
        rows.push_back(make_row(CMD_QUERY, '0, 7'd65, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '1, CAT_TOP, TYPED, ST_DONE, '0, '0));
        // unused command code leaves the table alone
        rows.push_back(make_row(CMD_UNUSED, '1, CAT_TOP, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_UNUSED, '0, '0, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '0, ALL_CATEGORY, PREDICTED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_CLEAR, '1, CAT_TOP, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, '0, ALL_CATEGORY, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'd255, ALL_CATEGORY, TYPED, ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_RECORD, 64'hAAAA_AAAA_AAAA_AAAA, 7'h55, PREDICTED,
                                ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_QUERY, 64'h5555_5555_5555_5555, 7'd1, PREDICTED,
                                ST_DONE, '0, '0));
        rows.push_back(make_row(CMD_CLEAR, '0, '0, TYPED, ST_DONE, '0, '0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            send_word(rows[i].cmd, rows[i].key, rows[i].cat, rows[i].typed, rows[i].want);
        end

        // random traffic in episodes: a mixed burst, pressure, a full-table pass, a quiet stretch,
        // then mixed bursts until the word budget is spent
        episode = 0;
        while (n_sent < WORD_TARGET) begin
            case (episode)
                1: begin
                    hold_req = 1'b1;
                    mixed_burst(40);
                end
                2: begin
                    fill_table();
                end
                3: begin
                    quiet = 1'b1;
                    mixed_burst(60);
                    quiet = 1'b0;
                end
                default: begin
                    mixed_burst($urandom_range(20, 50));
                end
            endcase
            episode++;
        end
        i_valid <= 1'b0;

        while (reply_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d words and %0d checked replies: %0d queries, %0d full drops",
                 n_sent, n_checked, n_queries, n_dropped);
        $display("one receiver hold-off of %0d cycles; input stalled while offered %0d cycles",
                 HOLD_CYCLES, n_offer_stalled);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
